FILE: sv/qhcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qhcs_pkg
// Shared types, constants and helpers of the quarter-hour chime scheduler.
// ----------------------------------------------------------------------------
package qhcs_pkg;

    localparam int NUM_TUNES = 8;
    localparam int MAX_RESULTS = 3;
    localparam int NOTE_W = 7;

    localparam logic [3:0] TUNE_MAX   = 4'(NUM_TUNES);
    localparam logic [6:0] NOTE_LO    = 7'd69;
    localparam logic [6:0] NOTE_HI    = 7'd91;
    localparam logic [6:0] VEL_DIV    = 7'd127;
    localparam logic [4:0] DAY_HOURS  = 5'd24;
    localparam logic [4:0] DIAL_HOURS = 5'd12;
    localparam logic [3:0] DIAL_TOP   = 4'd12;
    localparam logic [3:0] MANUAL_STRIKES = 4'd3;
    localparam logic [7:0] PREV_NONE  = 8'hFF;

    localparam logic [5:0] MIN_Q1 = 6'd15;
    localparam logic [5:0] MIN_Q2 = 6'd30;
    localparam logic [5:0] MIN_Q3 = 6'd45;
    localparam logic [5:0] MIN_Q4 = 6'd0;

    localparam logic [2:0] QTR_NONE = 3'd0;
    localparam logic [2:0] QTR_1    = 3'd1;
    localparam logic [2:0] QTR_2    = 3'd2;
    localparam logic [2:0] QTR_3    = 3'd3;
    localparam logic [2:0] QTR_4    = 3'd4;

    // register reset values
    localparam logic [1:0]  RST_MODE_FLAGS     = 2'd3;
    localparam logic [3:0]  RST_TUNE_NUMBER    = 4'd5;
    localparam logic [6:0]  RST_TUNE_VELOCITY  = 7'd127;
    localparam logic [6:0]  RST_HOUR_VELOCITY  = 7'd127;
    localparam logic [6:0]  RST_QUIET_SCALE    = 7'd64;
    localparam logic [9:0]  RST_QUIET_WINDOW   = 10'd647;
    localparam logic [9:0]  RST_SILENCE_WINDOW = 10'd711;
    localparam logic [20:0] RST_STRIKE_NOTES   = 21'd9926;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_MODE_FLAGS     = 3'd0,
        REG_TUNE_NUMBER    = 3'd1,
        REG_TUNE_VELOCITY  = 3'd2,
        REG_HOUR_VELOCITY  = 3'd3,
        REG_QUIET_SCALE    = 3'd4,
        REG_QUIET_WINDOW   = 3'd5,
        REG_SILENCE_WINDOW = 3'd6,
        REG_STRIKE_NOTES   = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_CHIME  = 2'd1,
        KIND_STRIKE = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]  mode_flags;
        logic [3:0]  tune_number;
        logic [6:0]  tune_velocity;
        logic [6:0]  hour_velocity;
        logic [6:0]  quiet_scale;
        logic [9:0]  quiet_window;
        logic [9:0]  silence_window;
        logic [20:0] strike_notes;
    } cfg_t;

    typedef struct packed {
        logic       cmd;
        logic       time_valid;
        logic [4:0] hour;
        logic [5:0] minute;
        logic       sequencer_playing;
        logic [2:0] manual_quarter;
    } in_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] quarter;
        logic [3:0] tune;
        logic [6:0] velocity;
        logic [6:0] note;
        logic [3:0] strike_count;
        logic       last;
    } out_item_t;

    // results of one item handed to the output buffer
    typedef struct packed {
        logic                             load;
        logic [1:0]                       cnt;
        out_item_t [MAX_RESULTS-1:0]      items;
    } res_bundle_t;

    // start in bits 9:5, end in bits 4:0; wraps past midnight
    function automatic logic in_window(input logic [9:0] win, input logic [4:0] h);
        logic [4:0] s;
        logic [4:0] e;
        logic       hit;
        s = win[9:5];
        e = win[4:0];
        if (s >= DAY_HOURS || e >= DAY_HOURS) begin
            hit = 1'b0;
        end else if (s < e) begin
            hit = (h >= s) && (h < e);
        end else if (s > e) begin
            hit = (h >= s) || (h < e);
        end else begin
            hit = 1'b0;
        end
        return hit;
    endfunction

endpackage
`default_nettype wire

FILE: sv/qhcs_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qhcs_cfg_regs
// APB register file holding the scheduler settings.
// ----------------------------------------------------------------------------
module qhcs_cfg_regs
    import qhcs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode_flags     <= RST_MODE_FLAGS;
            cfg_reg.tune_number    <= RST_TUNE_NUMBER;
            cfg_reg.tune_velocity  <= RST_TUNE_VELOCITY;
            cfg_reg.hour_velocity  <= RST_HOUR_VELOCITY;
            cfg_reg.quiet_scale    <= RST_QUIET_SCALE;
            cfg_reg.quiet_window   <= RST_QUIET_WINDOW;
            cfg_reg.silence_window <= RST_SILENCE_WINDOW;
            cfg_reg.strike_notes   <= RST_STRIKE_NOTES;
        end else if (wr_en) begin
            case (idx)
                REG_MODE_FLAGS:     cfg_reg.mode_flags     <= pwdata[1:0];
                REG_TUNE_NUMBER:    cfg_reg.tune_number    <= pwdata[3:0];
                REG_TUNE_VELOCITY:  cfg_reg.tune_velocity  <= pwdata[6:0];
                REG_HOUR_VELOCITY:  cfg_reg.hour_velocity  <= pwdata[6:0];
                REG_QUIET_SCALE:    cfg_reg.quiet_scale    <= pwdata[6:0];
                REG_QUIET_WINDOW:   cfg_reg.quiet_window   <= pwdata[9:0];
                REG_SILENCE_WINDOW: cfg_reg.silence_window <= pwdata[9:0];
                REG_STRIKE_NOTES:   cfg_reg.strike_notes   <= pwdata[20:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            REG_MODE_FLAGS:     prdata = APB_DATA_W'(cfg_reg.mode_flags);
            REG_TUNE_NUMBER:    prdata = APB_DATA_W'(cfg_reg.tune_number);
            REG_TUNE_VELOCITY:  prdata = APB_DATA_W'(cfg_reg.tune_velocity);
            REG_HOUR_VELOCITY:  prdata = APB_DATA_W'(cfg_reg.hour_velocity);
            REG_QUIET_SCALE:    prdata = APB_DATA_W'(cfg_reg.quiet_scale);
            REG_QUIET_WINDOW:   prdata = APB_DATA_W'(cfg_reg.quiet_window);
            REG_SILENCE_WINDOW: prdata = APB_DATA_W'(cfg_reg.silence_window);
            REG_STRIKE_NOTES:   prdata = APB_DATA_W'(cfg_reg.strike_notes);
            default:            prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/qhcs_sched.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qhcs_sched
// Input register, scheduler state and the single-pass decision logic.
// ----------------------------------------------------------------------------
module qhcs_sched
    import qhcs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    input  wire logic        buf_free,
    output res_bundle_t      res
);

    logic     in_valid_reg;
    in_item_t in_data_reg;
    logic     proc;

    logic       chime_busy_reg,     chime_busy_next;
    logic       strike_pending_reg, strike_pending_next;
    logic [3:0] pending_count_reg,  pending_count_next;
    logic [7:0] prev_minute_reg,    prev_minute_next;
    logic [7:0] prev_hour_reg,      prev_hour_next;

    // item decode
    logic [4:0]  qh;
    logic        tune_ok;
    logic        quiet;
    logic [6:0]  base_vel;
    logic [13:0] prod;
    logic [6:0]  q0;
    logic [7:0]  rem;
    logic [6:0]  vel;
    logic        do_chime;
    logic        do_strike;
    logic [2:0]  chime_q;
    logic [2:0]  tick_q;
    logic [4:0]  dial_h;
    logic [3:0]  dial_cnt;
    logic [6:0]  note_v [MAX_RESULTS];
    logic [1:0]  n_res;
    out_item_t [MAX_RESULTS-1:0] items;

    assign proc    = in_valid_reg && buf_free;
    assign s_ready = !in_valid_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // quiet-hour velocity: base * scale / 127, floor
    always_comb begin
        qh       = in_data_reg.time_valid ? in_data_reg.hour : 5'd0;
        tune_ok  = (cfg.tune_number != 4'd0) && (cfg.tune_number <= TUNE_MAX);
        quiet    = in_window(cfg.quiet_window, qh);
        // only strikes come from the busy-release path of a tick
        base_vel = (!in_data_reg.cmd && chime_busy_reg) ? cfg.hour_velocity
                                                          : cfg.tune_velocity;
        prod     = 14'(base_vel) * 14'(cfg.quiet_scale);
        q0       = prod[13:7];
        rem      = {1'b0, prod[6:0]} + {1'b0, q0};
        vel      = quiet ? (q0 + 7'(rem >= {1'b0, VEL_DIV})) : base_vel;
    end

    always_comb begin
        dial_h = in_data_reg.hour;
        if (in_data_reg.hour >= DAY_HOURS) begin
            dial_h = in_data_reg.hour - DAY_HOURS;
        end else if (in_data_reg.hour >= DIAL_HOURS) begin
            dial_h = in_data_reg.hour - DIAL_HOURS;
        end
        dial_cnt = (dial_h == 5'd0) ? DIAL_TOP : dial_h[3:0];

        case (in_data_reg.minute)
            MIN_Q1:  tick_q = QTR_1;
            MIN_Q2:  tick_q = QTR_2;
            MIN_Q3:  tick_q = QTR_3;
            MIN_Q4:  tick_q = QTR_4;
            default: tick_q = QTR_NONE;
        endcase
    end

    always_comb begin
        chime_busy_next     = chime_busy_reg;
        strike_pending_next = strike_pending_reg;
        pending_count_next  = pending_count_reg;
        prev_minute_next    = prev_minute_reg;
        prev_hour_next      = prev_hour_reg;
        do_chime            = 1'b0;
        do_strike           = 1'b0;
        chime_q             = QTR_NONE;

        if (in_data_reg.cmd) begin
            if (in_data_reg.manual_quarter inside {[QTR_1:QTR_4]}) begin
                chime_q  = in_data_reg.manual_quarter;
                do_chime = tune_ok;
                if (in_data_reg.manual_quarter == QTR_4 && cfg.mode_flags[1]) begin
                    strike_pending_next = 1'b1;
                    pending_count_next  = MANUAL_STRIKES;
                end
            end
        end else if (chime_busy_reg) begin
            if (!in_data_reg.sequencer_playing) begin
                chime_busy_next = 1'b0;
                if (strike_pending_reg) begin
                    strike_pending_next = 1'b0;
                    do_strike           = 1'b1;
                end
            end
        end else if (cfg.mode_flags[0] && in_data_reg.time_valid) begin
            if (in_window(cfg.silence_window, in_data_reg.hour)) begin
                prev_minute_next = 8'(in_data_reg.minute);
                prev_hour_next   = 8'(in_data_reg.hour);
            end else if (8'(in_data_reg.minute) != prev_minute_reg) begin
                prev_minute_next = 8'(in_data_reg.minute);
                if (tick_q != QTR_NONE) begin
                    chime_q  = tick_q;
                    do_chime = tune_ok;
                    if (tick_q == QTR_4 && cfg.mode_flags[1]
                        && 8'(in_data_reg.hour) != prev_hour_reg) begin
                        prev_hour_next      = 8'(in_data_reg.hour);
                        strike_pending_next = 1'b1;
                        pending_count_next  = dial_cnt;
                    end
                end
            end
        end

        if (do_chime) begin
            chime_busy_next = 1'b1;
        end
    end

    // result list: one chime, or the in-range strike notes packed in order
    always_comb begin
        items = '0;
        n_res = 2'd0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            note_v[i] = cfg.strike_notes[NOTE_W*i +: NOTE_W];
        end
        if (do_chime) begin
            items[0].kind     = KIND_CHIME;
            items[0].quarter  = chime_q;
            items[0].tune     = cfg.tune_number;
            items[0].velocity = vel;
            n_res             = 2'd1;
        end else if (do_strike) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                if (note_v[i] inside {[NOTE_LO:NOTE_HI]}) begin
                    items[n_res].kind         = KIND_STRIKE;
                    items[n_res].velocity     = vel;
                    items[n_res].note         = note_v[i];
                    items[n_res].strike_count = pending_count_reg;
                    n_res                     = n_res + 2'd1;
                end
            end
        end
        if (n_res != 2'd0) begin
            items[n_res - 2'd1].last = 1'b1;
        end
    end

    assign res.load  = proc && (n_res != 2'd0);
    assign res.cnt   = n_res;
    assign res.items = items;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chime_busy_reg     <= 1'b0;
            strike_pending_reg <= 1'b0;
            pending_count_reg  <= 4'd0;
            prev_minute_reg    <= PREV_NONE;
            prev_hour_reg      <= PREV_NONE;
        end else if (proc) begin
            chime_busy_reg     <= chime_busy_next;
            strike_pending_reg <= strike_pending_next;
            pending_count_reg  <= pending_count_next;
            prev_minute_reg    <= prev_minute_next;
            prev_hour_reg      <= prev_hour_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_pending_count: assert property (@(posedge aclk) disable iff (!aresetn)
        strike_pending_reg |-> (pending_count_reg >= 4'd1 && pending_count_reg <= DIAL_TOP))
        else $error("pending strike count out of dial range");

    a_chime_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.load && res.items[0].kind == KIND_CHIME) |-> (res.cnt == 2'd1 && res.items[0].last))
        else $error("chime item must be a single, final result");
`endif

endmodule
`default_nettype wire

FILE: sv/qhcs_outbuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qhcs_outbuf
// Three-deep result buffer; head entry drives the result channel.
// ----------------------------------------------------------------------------
module qhcs_outbuf
    import qhcs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire res_bundle_t res,
    output logic             buf_free,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data
);

    logic [1:0]                  cnt_reg;
    out_item_t [MAX_RESULTS-1:0] items_reg;
    logic                        pop;

    assign m_valid  = (cnt_reg != 2'd0);
    assign m_data   = items_reg[0];
    assign pop      = m_valid && m_ready;
    assign buf_free = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (res.load) begin
            cnt_reg <= res.cnt;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.load) begin
            items_reg <= res.items;
        end else if (pop) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                items_reg[i] <= items_reg[i+1];
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_last_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last == (cnt_reg == 2'd1)))
        else $error("last flag does not match final buffered result");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res.load |-> buf_free)
        else $error("result load while buffer still holds results");
`endif

endmodule
`default_nettype wire

FILE: sv/quarter_hour_chime_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quarter_hour_chime_scheduler
// Turns time ticks and manual requests into chime and hour-strike commands.
// ----------------------------------------------------------------------------
// An accepted item lands in an input register; from there its decision is
// made in a single pass (window checks, quarter decode, 7x7 quiet-scale
// multiply with a divide-by-127 correction) and its results are loaded into a
// three-entry result buffer, whose head drives m_valid; the load waits while
// the buffer is not free. A chime item, or one with no results, streams at
// one per clock while m_ready stays high. A strike item yields one result per
// in-range strike note (up to three), sent one per cycle while m_ready is
// high, so it holds the result buffer until those are sent; the input register
// meanwhile takes the next item. Sustained throughput is set by the single
// result port. Settings are written over APB at byte address 4*index and
// should only change while the block is idle.
// ----------------------------------------------------------------------------
module quarter_hour_chime_scheduler
    import qhcs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // input items
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    // result items
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data
);

    cfg_t        cfg;
    res_bundle_t res;
    logic        buf_free;

    // settings
    qhcs_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register, scheduler state, decision logic
    qhcs_sched u_sched (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .buf_free (buf_free),
        .res      (res)
    );

    // result buffer, drains one item per cycle while m_ready is high
    qhcs_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .buf_free (buf_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

FILE: tb/quarter_hour_chime_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quarter_hour_chime_scheduler_tb
// Self-checking bench for the chime scheduler. A directed table walks the
// quarter marks, hour strikes, manual requests, silence and quiet windows;
// random phases then run a wall clock under several register settings.
// Every result is compared with a behavioral predictor or with the row's typed result.
// ----------------------------------------------------------------------------
module quarter_hour_chime_scheduler_tb;
    import qhcs_pkg::*;

    localparam int ITEMS_PER_PHASE = 58;
    localparam int NUM_PHASES      = 6;
    localparam int SETTLE_CYCLES   = 8;     // pipeline is two deep, keep margin
    localparam int STALL_LIMIT     = 4000;  // cycles with no handshake or register access
    localparam int DIR_ROWS        = 21;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL = 2'd0,   // predictor decides
        CHK_NONE  = 2'd1,   // no result at all
        CHK_ONE   = 2'd2    // exactly the one result typed in the row
    } row_check_t;

    typedef struct packed {
        in_item_t   stim;
        row_check_t how;
        out_item_t  res;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;

    quarter_hour_chime_scheduler dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor state: settings plus the scheduler's own memory
    // ------------------------------------------------------------------
    cfg_t       cfg = '{RST_MODE_FLAGS, RST_TUNE_NUMBER, RST_TUNE_VELOCITY,
                        RST_HOUR_VELOCITY, RST_QUIET_SCALE, RST_QUIET_WINDOW,
                        RST_SILENCE_WINDOW, RST_STRIKE_NOTES};
    logic       chime_on    = 1'b0;       // chime started, sequencer not yet seen idle
    logic       strike_due  = 1'b0;
    logic [3:0] strike_reps = 4'd0;
    logic [7:0] seen_min    = PREV_NONE;
    logic [7:0] seen_hr     = PREV_NONE;

    out_item_t  step_res[$];              // results of the item just accepted
    out_item_t  due_cmds[$];              // commands still owed by the block
    out_item_t  want;

    // settings of the item being offered, read by the monitor on acceptance
    row_check_t row_how = CHK_MODEL;
    out_item_t  row_res = '0;

    int         fail_cnt     = 0;
    int         idle_run     = 0;
    int         src_gap_pct  = 0;
    int         sink_hold_pct = 0;
    logic [4:0] wall_h = 5'd0;
    logic [5:0] wall_m = 6'd0;

    dir_row_t   dir_tab [DIR_ROWS];

    // start hour in 9:5, end hour in 4:0; out-of-day or equal bounds disable it
    function automatic bit window_hit(logic [9:0] win, logic [4:0] h);
        int s;
        int e;
        s = int'(win[9:5]);
        e = int'(win[4:0]);
        if (s >= int'(DAY_HOURS) || e >= int'(DAY_HOURS) || s == e) return 1'b0;
        if (s < e) return (int'(h) >= s) && (int'(h) < e);
        return (int'(h) >= s) || (int'(h) < e);
    endfunction

    // quiet hours scale by quiet_scale/127, truncating
    function automatic logic [6:0] eff_velocity(logic [6:0] base, logic [4:0] h);
        if (!window_hit(cfg.quiet_window, h)) return base;
        return 7'((int'(base) * int'(cfg.quiet_scale)) / int'(VEL_DIV));
    endfunction

    function automatic void add_chime(logic [2:0] q, logic [4:0] h);
        out_item_t r;
        if (cfg.tune_number == 4'd0 || cfg.tune_number > TUNE_MAX || q == QTR_NONE) return;
        r          = '0;
        r.kind     = KIND_CHIME;
        r.quarter  = q;
        r.tune     = cfg.tune_number;
        r.velocity = eff_velocity(cfg.tune_velocity, h);
        step_res.push_back(r);
        chime_on = 1'b1;
    endfunction

    // advance the predictor by one accepted item, leaving its results in step_res
    function automatic void schedule_item(in_item_t it);
        logic [4:0] qh;
        logic [2:0] q;
        logic [3:0] reps;
        logic [6:0] n;
        out_item_t  r;
        step_res.delete();
        qh = it.time_valid ? it.hour : 5'd0;
        if (it.cmd) begin
            // manual request ignores the chime-enable bit
            if (it.manual_quarter >= QTR_1 && it.manual_quarter <= QTR_4) begin
                add_chime(it.manual_quarter, qh);
                if (it.manual_quarter == QTR_4 && cfg.mode_flags[1]) begin
                    strike_due  = 1'b1;
                    strike_reps = MANUAL_STRIKES;
                end
            end
        end else if (chime_on) begin
            // while a chime runs a tick only looks for the sequencer going idle
            if (!it.sequencer_playing) begin
                chime_on = 1'b0;
                if (strike_due) begin
                    strike_due = 1'b0;
                    for (int i = 0; i < MAX_RESULTS; i++) begin
                        n = cfg.strike_notes[NOTE_W*i +: NOTE_W];
                        if (n >= NOTE_LO && n <= NOTE_HI) begin
                            r              = '0;
                            r.kind         = KIND_STRIKE;
                            r.velocity     = eff_velocity(cfg.hour_velocity, qh);
                            r.note         = n;
                            r.strike_count = strike_reps;
                            step_res.push_back(r);
                        end
                    end
                end
            end
        end else if (cfg.mode_flags[0] && it.time_valid) begin
            if (window_hit(cfg.silence_window, it.hour)) begin
                seen_min = {2'b00, it.minute};
                seen_hr  = {3'b000, it.hour};
            end else if ({2'b00, it.minute} != seen_min) begin
                seen_min = {2'b00, it.minute};
                case (it.minute)
                    MIN_Q1:  q = QTR_1;
                    MIN_Q2:  q = QTR_2;
                    MIN_Q3:  q = QTR_3;
                    MIN_Q4:  q = QTR_4;
                    default: q = QTR_NONE;
                endcase
                if (q != QTR_NONE) begin
                    add_chime(q, it.hour);
                    // strike once per hour, counted on a 12-hour dial
                    if (q == QTR_4 && cfg.mode_flags[1] && {3'b000, it.hour} != seen_hr) begin
                        seen_hr = {3'b000, it.hour};
                        reps = 4'(it.hour % DIAL_HOURS);
                        if (reps == 4'd0) reps = DIAL_TOP;
                        strike_due  = 1'b1;
                        strike_reps = reps;
                    end
                end
            end
        end
        if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
    endfunction

    function automatic void check_field(string fld, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", fld, exp_v, act_v);
            fail_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                // the predictor always runs so its state tracks the block
                schedule_item(s_data);
                case (row_how)
                    CHK_MODEL: foreach (step_res[i]) due_cmds.push_back(step_res[i]);
                    CHK_ONE:   due_cmds.push_back(row_res);
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (due_cmds.size() == 0) begin
                    $error("result with nothing expected: kind %0d note %0d",
                           m_data.kind, m_data.note);
                    fail_cnt++;
                end else begin
                    want = due_cmds.pop_front();
                    check_field("kind", int'(want.kind), int'(m_data.kind));
                    check_field("quarter", int'(want.quarter), int'(m_data.quarter));
                    check_field("tune", int'(want.tune), int'(m_data.tune));
                    check_field("velocity", int'(want.velocity), int'(m_data.velocity));
                    check_field("note", int'(want.note), int'(m_data.note));
                    check_field("strike_count", int'(want.strike_count),
                                int'(m_data.strike_count));
                    check_field("last", int'(want.last), int'(m_data.last));
                end
            end
        end
    end

    // Watchdog: any handshake or register access counts as progress
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_run <= 0;
        end else if (idle_run >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles, %0d results outstanding",
                   idle_run, due_cmds.size());
            $display("quarter_hour_chime_scheduler_tb: done, errors");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    // Result side back-pressure, redrawn every cycle
    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= sink_hold_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic in_item_t mk(logic cmd, logic tv, logic [4:0] h, logic [5:0] m,
                                    logic busy, logic [2:0] mq);
        in_item_t it;
        it.cmd               = cmd;
        it.time_valid        = tv;
        it.hour              = h;
        it.minute            = m;
        it.sequencer_playing = busy;
        it.manual_quarter    = mq;
        return it;
    endfunction

    // chime result under the reset tune
    function automatic out_item_t chime_exp(logic [2:0] q, logic [6:0] vel);
        out_item_t r;
        r          = '0;
        r.kind     = KIND_CHIME;
        r.quarter  = q;
        r.tune     = RST_TUNE_NUMBER;
        r.velocity = vel;
        r.last     = 1'b1;
        return r;
    endfunction

    // Mostly ticks of a running wall clock that lands on quarter marks,
    // then manual requests, then raw noise over every field bit.
    function automatic in_item_t wall_clock_item();
        in_item_t    it;
        logic [31:0] raw;
        int          sel;
        int          step;
        sel = $urandom_range(99);
        if (sel < 62) begin
            step = $urandom_range(9);
            if (step < 6) begin
                if (wall_m >= 6'd45) begin
                    wall_m = 6'd0;
                    wall_h = (wall_h == 5'd23) ? 5'd0 : wall_h + 5'd1;
                end else begin
                    wall_m = 6'((wall_m / 15 + 1) * 15);
                end
            end else if (step == 9) begin
                wall_m = 6'($urandom_range(59));
                if ($urandom_range(3) == 0) wall_h = 5'($urandom_range(23));
            end
            // step 6..8 repeats the same minute
            it = mk(1'b0, $urandom_range(9) != 0, wall_h, wall_m,
                    1'($urandom_range(1)), 3'($urandom_range(7)));
        end else if (sel < 82) begin
            raw = $urandom;
            it = raw[$bits(in_item_t)-1:0];
            it.cmd = 1'b1;
            it.manual_quarter = ($urandom_range(3) == 0) ? 3'($urandom_range(7))
                                                         : 3'($urandom_range(1, 4));
        end else begin
            raw = $urandom;
            it = raw[$bits(in_item_t)-1:0];
        end
        return it;
    endfunction

    // register sets per phase: both extremes, out-of-range tunes, no valid notes
    function automatic cfg_t phase_cfg(int ph);
        cfg_t c;
        c.mode_flags     = 2'($urandom);
        c.tune_number    = 4'($urandom_range(1, NUM_TUNES));
        c.tune_velocity  = 7'($urandom_range(1, 127));
        c.hour_velocity  = 7'($urandom_range(1, 127));
        c.quiet_scale    = 7'($urandom_range(127));
        c.quiet_window   = 10'($urandom);
        c.silence_window = 10'($urandom);
        c.strike_notes   = {7'($urandom_range(60, 100)), 7'($urandom_range(60, 100)),
                            7'($urandom_range(60, 100))};
        case (ph)
            0: c = '{2'd3, TUNE_MAX, 7'd127, 7'd127, 7'd127, 10'd1023, 10'd0,
                     {7'd80, 7'd91, 7'd69}};
            1: c = '{2'd0, 4'd1, 7'd1, 7'd1, 7'd0, {5'd0, 5'd23}, {5'd23, 5'd24},
                     {7'd69, 7'd69, 7'd69}};
            2: begin
                c.mode_flags   = 2'd3;
                c.tune_number  = 4'd0;
                c.strike_notes = 21'd0;
            end
            3: begin
                c.mode_flags   = 2'd3;
                c.strike_notes = 21'h1FFFFF;    // every note out of range
            end
            4: c.tune_number = 4'($urandom_range(NUM_TUNES + 1, 15));
            default: c.mode_flags = 2'd3;
        endcase
        return c;
    endfunction

    task automatic apb_write(reg_idx_t r, logic [31:0] v);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {r, 2'b00};
        pwdata  = v;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_cfg(cfg_t c);
        reg_idx_t    r;
        logic [31:0] v;
        for (int i = 0; i < 8; i++) begin
            r = reg_idx_t'(i);
            case (r)
                REG_MODE_FLAGS:     v = 32'(c.mode_flags);
                REG_TUNE_NUMBER:    v = 32'(c.tune_number);
                REG_TUNE_VELOCITY:  v = 32'(c.tune_velocity);
                REG_HOUR_VELOCITY:  v = 32'(c.hour_velocity);
                REG_QUIET_SCALE:    v = 32'(c.quiet_scale);
                REG_QUIET_WINDOW:   v = 32'(c.quiet_window);
                REG_SILENCE_WINDOW: v = 32'(c.silence_window);
                default:            v = 32'(c.strike_notes);
            endcase
            apb_write(r, v);
        end
        cfg = c;    // block is idle, so the predictor takes the set at once
    endtask

    // offer one item; valid holds until the block takes it
    task automatic put_item(in_item_t it, row_check_t how, out_item_t res);
        @(negedge aclk);
        while ($urandom_range(99) < src_gap_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        row_how = how;
        row_res = res;
        s_data  = it;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid, collect every owed result, then let the pipeline empty
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (due_cmds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // three pacing stages: slow sink, then slow source, then full rate
    task automatic set_pace(int stage);
        case (stage)
            0: begin
                src_gap_pct   = 12;
                sink_hold_pct = 75;
            end
            1: begin
                src_gap_pct   = 75;
                sink_hold_pct = 12;
            end
            default: begin
                src_gap_pct   = 0;
                sink_hold_pct = 0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;

        // Directed walk under reset settings: quiet 20..7, silence 22..7,
        // strike notes 70 and 77, tune 5.
        //            cmd   tv    hour    min    busy  mq
        dir_tab = '{
            // top of the hour at noon: quarter 4, strike of 12 queued
            '{mk(1'b0, 1'b1, 5'd12, 6'd0,  1'b0, 3'd0), CHK_ONE,   chime_exp(QTR_4, 7'd127)},
            // sequencer still busy: nothing
            '{mk(1'b0, 1'b1, 5'd12, 6'd1,  1'b1, 3'd0), CHK_NONE,  '0},
            // sequencer idle: strike on both notes
            '{mk(1'b0, 1'b1, 5'd12, 6'd2,  1'b0, 3'd0), CHK_MODEL, '0},
            '{mk(1'b0, 1'b1, 5'd12, 6'd15, 1'b0, 3'd0), CHK_ONE,   chime_exp(QTR_1, 7'd127)},
            // manual quarters outside 1..4 are dropped
            '{mk(1'b1, 1'b1, 5'd12, 6'd15, 1'b0, 3'd0), CHK_NONE,  '0},
            '{mk(1'b1, 1'b1, 5'd12, 6'd15, 1'b0, 3'd7), CHK_NONE,  '0},
            // manual quarter 4 with clock unsynced: hour 0 is quiet, 3 strikes
            '{mk(1'b1, 1'b0, 5'd31, 6'd0,  1'b0, 3'd4), CHK_ONE,   chime_exp(QTR_4, 7'd64)},
            '{mk(1'b0, 1'b0, 5'd0,  6'd0,  1'b0, 3'd0), CHK_MODEL, '0},
            // silence window, wrapping past midnight
            '{mk(1'b0, 1'b1, 5'd23, 6'd0,  1'b0, 3'd0), CHK_NONE,  '0},
            // end hour itself is outside both windows
            '{mk(1'b0, 1'b1, 5'd7,  6'd30, 1'b0, 3'd0), CHK_ONE,   chime_exp(QTR_2, 7'd127)},
            '{mk(1'b0, 1'b1, 5'd7,  6'd30, 1'b0, 3'd0), CHK_NONE,  '0},
            // same minute seen again
            '{mk(1'b0, 1'b1, 5'd7,  6'd30, 1'b0, 3'd0), CHK_NONE,  '0},
            // hour above 23 compares as given and falls in the window
            '{mk(1'b0, 1'b1, 5'd31, 6'd63, 1'b0, 3'd0), CHK_NONE,  '0},
            '{mk(1'b0, 1'b1, 5'd8,  6'd45, 1'b0, 3'd0), CHK_ONE,   chime_exp(QTR_3, 7'd127)},
            '{mk(1'b0, 1'b1, 5'd8,  6'd45, 1'b0, 3'd0), CHK_NONE,  '0},
            '{mk(1'b0, 1'b1, 5'd8,  6'd0,  1'b0, 3'd0), CHK_ONE,   chime_exp(QTR_4, 7'd127)},
            '{mk(1'b0, 1'b1, 5'd8,  6'd0,  1'b1, 3'd0), CHK_NONE,  '0},
            '{mk(1'b0, 1'b1, 5'd8,  6'd0,  1'b0, 3'd0), CHK_MODEL, '0},
            // tick without time sync while idle
            '{mk(1'b0, 1'b0, 5'd0,  6'd0,  1'b0, 3'd0), CHK_NONE,  '0},
            // every field bit high but the manual quarter (3), quiet at hour 31
            '{mk(1'b1, 1'b1, 5'd31, 6'd63, 1'b1, 3'd3), CHK_ONE,   chime_exp(QTR_3, 7'd64)},
            '{mk(1'b0, 1'b1, 5'd31, 6'd63, 1'b0, 3'd0), CHK_NONE,  '0}
        };

        set_pace(0);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_tab[i]) put_item(dir_tab[i].stim, dir_tab[i].how, dir_tab[i].res);
        settle();

        // Random phases, each under a fresh register set
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_pace(ph / 2);
            apply_cfg(phase_cfg(ph));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) put_item(wall_clock_item(), CHK_MODEL, '0);
            settle();
        end

        if (fail_cnt == 0) begin
            $display("quarter_hour_chime_scheduler_tb: done, clean");
        end else begin
            $display("quarter_hour_chime_scheduler_tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/qhcs_pkg.sv
sv/qhcs_cfg_regs.sv
sv/qhcs_sched.sv
sv/qhcs_outbuf.sv
sv/quarter_hour_chime_scheduler.sv
tb/quarter_hour_chime_scheduler_tb.sv
